@@ sv/mmra_pkg.sv @@
`default_nettype none

package mmra_pkg;

	localparam int COUNT_BITS = 24;
	localparam int DATA_W = 32;
	localparam int ROOT_W = DATA_W / 2;
	localparam int REM_W = (COUNT_BITS + 1 > ROOT_W + 3) ? COUNT_BITS + 1 : ROOT_W + 3;
	localparam int DIV_STEPS = DATA_W;
	localparam int SQRT_STEPS = ROOT_W;
	localparam int STEP_W = $clog2(DIV_STEPS);

	typedef enum logic [2:0] {
		MODE_MAX = 3'd0,
		MODE_MIN = 3'd1,
		MODE_MEAN = 3'd2,
		MODE_SUM = 3'd3,
		MODE_SUM_SQUARE = 3'd4,
		MODE_L1 = 3'd5,
		MODE_L2 = 3'd6,
		MODE_PROD = 3'd7
	} mode_t;

	localparam mode_t MODE_RESET = MODE_SUM;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_ACC,
		ST_DIV,
		ST_SQRT,
		ST_DONE
	} state_t;

endpackage

`default_nettype wire

@@ sv/multi_mode_reduction_accumulator_unit.sv @@
// Reduces a stream of signed 32-bit elements, one group at a time, under the mode in
// reduce_mode (max, min, mean, sum, sum of squares, L1, L2, product); group_last ends a
// group and yields one result. Every element goes through the accepting cycle, one
// pass through the shared 32x32 multiplier (square or running product), and the accumulate
// step; in_ready is low during the multiply and accumulate steps. The last element of a
// group then goes through the bit-serial divider in mean mode, or through the bit-serial
// square root in L2 mode when the sum is not negative, and then loads the output register; a
// result still waiting in the output register holds the block in the load state. Write
// reduce_mode only while idle.
`default_nettype none

module multi_mode_reduction_accumulator_unit import mmra_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic cfg_valid,
	output logic cfg_ready,
	input wire logic [2:0] reduce_mode,
	input wire logic in_valid,
	output logic in_ready,
	input wire logic signed [DATA_W-1:0] element_value,
	input wire logic group_last,
	output logic out_valid,
	input wire logic out_ready,
	output logic signed [DATA_W-1:0] reduced_value,
	output logic domain_error
);

	state_t state_q, state_d;
	mode_t cfg_mode_q, item_mode_q;
	logic group_start_q;
	logic last_q;
	logic [DATA_W-1:0] elem_q;
	logic [DATA_W-1:0] total_q;
	logic [DATA_W-1:0] prod_s1;
	logic [COUNT_BITS-1:0] count_q;
	logic [DATA_W-1:0] work_q;
	logic [REM_W-1:0] rem_q;
	logic [ROOT_W-1:0] root_q;
	logic [STEP_W-1:0] step_q;
	logic neg_q;
	logic out_valid_q;
	logic [DATA_W-1:0] result_q;
	logic error_q;

	logic accept;
	logic load_out;
	logic [DATA_W-1:0] mul_a;
	logic [DATA_W-1:0] mul_lo;
	logic [DATA_W-1:0] elem_abs;
	logic [DATA_W-1:0] acc_total;
	logic [DATA_W-1:0] acc_abs;
	logic [DATA_W-1:0] start_total;
	logic [REM_W-1:0] cand;
	logic [REM_W-1:0] sub;
	logic [REM_W:0] diff;
	logic ge;
	logic [DATA_W-1:0] result_d;
	logic error_d;

	assign accept = in_valid && in_ready;
	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign reduced_value = result_q;
	assign domain_error = error_q;

	always_comb begin
		unique case (cfg_mode_q)
			MODE_MAX, MODE_MIN: start_total = element_value;
			MODE_PROD: start_total = DATA_W'(1);
			default: start_total = '0;
		endcase
	end

	assign mul_a = (item_mode_q == MODE_PROD) ? total_q : elem_q;
	assign mul_lo = mul_a * elem_q;
	assign elem_abs = elem_q[DATA_W-1] ? (DATA_W'(0) - elem_q) : elem_q;

	always_comb begin
		unique case (item_mode_q)
			MODE_MAX: acc_total = ($signed(elem_q) > $signed(total_q)) ? elem_q : total_q;
			MODE_MIN: acc_total = ($signed(elem_q) < $signed(total_q)) ? elem_q : total_q;
			MODE_SUM_SQUARE, MODE_L2: acc_total = total_q + prod_s1;
			MODE_L1: acc_total = total_q + elem_abs;
			MODE_PROD: acc_total = prod_s1;
			MODE_MEAN, MODE_SUM: acc_total = total_q + elem_q;
			default: acc_total = total_q;
		endcase
	end

	assign acc_abs = acc_total[DATA_W-1] ? (DATA_W'(0) - acc_total) : acc_total;

	// shared restoring step for divide and square root
	always_comb begin
		if (state_q == ST_DIV) begin
			cand = {rem_q[REM_W-2:0], work_q[DATA_W-1]};
			sub = {{(REM_W-COUNT_BITS){1'b0}}, count_q};
		end else begin
			cand = {rem_q[REM_W-3:0], work_q[DATA_W-1:DATA_W-2]};
			sub = {{(REM_W-ROOT_W-2){1'b0}}, root_q, 2'b01};
		end
		diff = {1'b0, cand} - {1'b0, sub};
		ge = !diff[REM_W];
	end

	always_comb begin
		error_d = 1'b0;
		unique case (item_mode_q)
			MODE_MEAN: result_d = neg_q ? (DATA_W'(0) - work_q) : work_q;
			MODE_L2: begin
				if (total_q[DATA_W-1]) begin
					result_d = '0;
					error_d = 1'b1;
				end else begin
					result_d = {{(DATA_W-ROOT_W){1'b0}}, root_q};
				end
			end
			default: result_d = total_q;
		endcase
	end

	assign load_out = (state_q == ST_DONE) && (!out_valid_q || out_ready);

	always_comb begin
		state_d = state_q;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) state_d = ST_MUL;
			end
			ST_MUL: state_d = ST_ACC;
			ST_ACC: begin
				if (!last_q) begin
					state_d = ST_IDLE;
				end else if (item_mode_q == MODE_MEAN) begin
					state_d = ST_DIV;
				end else if (item_mode_q == MODE_L2 && !acc_total[DATA_W-1]) begin
					state_d = ST_SQRT;
				end else begin
					state_d = ST_DONE;
				end
			end
			ST_DIV, ST_SQRT: begin
				if (step_q == '0) state_d = ST_DONE;
			end
			ST_DONE: begin
				if (load_out) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cfg_mode_q <= MODE_RESET;
			group_start_q <= 1'b1;
			count_q <= '0;
			total_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_valid && cfg_ready) cfg_mode_q <= mode_t'(reduce_mode);
			if (accept && group_start_q) begin
				total_q <= start_total;
				count_q <= '0;
			end
			if (state_q == ST_ACC) begin
				total_q <= acc_total;
				if (count_q != '1) count_q <= count_q + 1'b1;
				group_start_q <= last_q;
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			elem_q <= element_value;
			last_q <= group_last;
			item_mode_q <= cfg_mode_q;
		end
		if (state_q == ST_MUL) prod_s1 <= mul_lo;
		unique case (state_q)
			ST_ACC: begin
				rem_q <= '0;
				root_q <= '0;
				neg_q <= acc_total[DATA_W-1];
				if (item_mode_q == MODE_MEAN) begin
					work_q <= acc_abs;
					step_q <= STEP_W'(DIV_STEPS - 1);
				end else begin
					work_q <= acc_total;
					step_q <= STEP_W'(SQRT_STEPS - 1);
				end
			end
			ST_DIV: begin
				rem_q <= ge ? diff[REM_W-1:0] : cand;
				work_q <= {work_q[DATA_W-2:0], ge};
				step_q <= step_q - 1'b1;
			end
			ST_SQRT: begin
				rem_q <= ge ? diff[REM_W-1:0] : cand;
				work_q <= {work_q[DATA_W-3:0], 2'b00};
				root_q <= {root_q[ROOT_W-2:0], ge};
				step_q <= step_q - 1'b1;
			end
			default: begin
			end
		endcase
		if (load_out) begin
			result_q <= result_d;
			error_q <= error_d;
		end
	end

endmodule

`default_nettype wire

@@ sv/mmra_checker.sv @@
`default_nettype none

module mmra_checker import mmra_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic cfg_valid,
	input wire logic cfg_ready,
	input wire logic [2:0] reduce_mode,
	input wire logic in_valid,
	input wire logic in_ready,
	input wire logic signed [DATA_W-1:0] element_value,
	input wire logic group_last,
	input wire logic out_valid,
	input wire logic out_ready,
	input wire logic signed [DATA_W-1:0] reduced_value,
	input wire logic domain_error
);

	// hold a stalled result
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(reduced_value) && $stable(domain_error))
	else $error("stalled result changed");

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && domain_error |-> reduced_value == '0)
	else $error("domain error with nonzero value");

	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
	else $error("ready right after a transaction");

	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && !group_last |=> !$rose(out_valid))
	else $error("result without a group end");

endmodule

bind multi_mode_reduction_accumulator_unit mmra_checker u_mmra_checker (.*);

`default_nettype wire
